### src/accel_tilt_angles_macros.svh
// assertion macros for the tilt angle block
// expects clk_i and rst_ni in the scope of use
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// condition checked at every clock edge out of reset
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ATA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ata_pkg.sv
// shared constants, types and arctangent table for the tilt angle block
// no dependencies
package ata_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD_SHIFT      = 8;
  localparam int ACC_W            = 34;
  localparam int ANG_W            = 32;
  localparam int SCALE_W          = 13;
  localparam int PROD_W           = ANG_W + SCALE_W;
  localparam int HUND_W           = 15;
  localparam int OUT_W            = 16;
  localparam int LVL_W            = 17;

  localparam logic [ANG_W-1:0]   HALF_PI_Q30        = 32'd1686629713;
  localparam logic [ANG_W-1:0]   PI_Q30             = 32'd3373259426;
  localparam logic [SCALE_W-1:0] HUNDREDTHS_PER_RAD = 13'd5729;
  localparam int                 ROUND_BIT          = 29;
  localparam int                 FRAC_BITS          = 30;
  localparam logic signed [LVL_W-1:0] QUARTER_TURN  = 17'sd9000;
  localparam logic signed [LVL_W-1:0] HALF_TURN     = 17'sd18000;
  localparam logic signed [LVL_W-1:0] FULL_TURN     = 17'sd36000;

  typedef struct packed {
    logic valid;
    logic degenerate;
    logic z_neg;
  } side_t;

  // atan(2^-i) in radians, Q30, truncated
  function automatic logic [ANG_W-1:0] atan_q30(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/ata_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on ata_pkg
module ata_sqrt import ata_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic [2*SAMPLE_WIDTH-1:0]             rad_i,
  output logic [SAMPLE_WIDTH+GUARD_SHIFT-1:0]   root_o
);

  localparam int SQ_W   = 2 * SAMPLE_WIDTH;
  localparam int RAD_W  = SQ_W + 2 * GUARD_SHIFT;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t        n;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2  = {s.rem[ROOT_W-1:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      n.rem  = rem2 - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = rem2;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  sq_stage_t first_s;
  sq_stage_t st_d [ROOT_W];
  sq_stage_t st_q [ROOT_W];

  always_comb begin
    first_s.rad  = {rad_i, {(2*GUARD_SHIFT){1'b0}}};
    first_s.rem  = '0;
    first_s.root = '0;
    st_d[0] = sq_step(first_s);
    for (int k = 1; k < ROOT_W; k++) begin
      st_d[k] = sq_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ROOT_W; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign root_o = st_q[ROOT_W-1].root;

endmodule

### src/ata_cordic.sv
// pipelined vectoring cordic giving an angle in radians, then scaled to hundredths
// depends on ata_pkg
module ata_cordic import ata_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic [SAMPLE_WIDTH+GUARD_SHIFT-1:0] leg_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      axis_i,
  output logic [PROD_W-1:0]                   prod_o
);

  localparam int ROOT_W = SAMPLE_WIDTH + GUARD_SHIFT;
  localparam int CW     = ROOT_W + 3;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cr_stage_t;

  function automatic cr_stage_t cr_step(input cr_stage_t s, input int i);
    cr_stage_t               n;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [ACC_W-1:0] da;
    dx = s.y >>> i;
    dy = s.x >>> i;
    da = signed'({{(ACC_W-ANG_W){1'b0}}, atan_q30(i)});
    if (!s.y[CW-1]) begin
      n.x   = s.x + dx;
      n.y   = s.y - dy;
      n.acc = s.acc + da;
    end else begin
      n.x   = s.x - dx;
      n.y   = s.y + dy;
      n.acc = s.acc - da;
    end
    return n;
  endfunction

  cr_stage_t            first_s;
  cr_stage_t            st_d [CORDIC_STEPS];
  cr_stage_t            st_q [CORDIC_STEPS];
  logic signed [CW-1:0] axis_ext;
  logic [ANG_W-1:0]     ang_clamp;
  cr_stage_t            last_s;

  always_comb begin
    axis_ext      = {{3{axis_i[SAMPLE_WIDTH-1]}}, axis_i, {GUARD_SHIFT{1'b0}}};
    first_s.x     = signed'({3'b000, leg_i});
    first_s.y     = -axis_ext;
    first_s.acc   = signed'({{(ACC_W-ANG_W){1'b0}}, HALF_PI_Q30});
    st_d[0] = cr_step(first_s, 0);
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      st_d[k] = cr_step(st_q[k-1], k);
    end
  end

  // clamp to [0, pi]
  always_comb begin
    last_s = st_q[CORDIC_STEPS-1];
    if (last_s.acc[ACC_W-1]) begin
      ang_clamp = '0;
    end else if (last_s.acc > signed'({{(ACC_W-ANG_W){1'b0}}, PI_Q30})) begin
      ang_clamp = PI_Q30;
    end else begin
      ang_clamp = last_s.acc[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      st_q[k] <= st_d[k];
    end
    prod_o <= PROD_W'(ang_clamp) * PROD_W'(HUNDREDTHS_PER_RAD);
  end

endmodule

### src/ata_lane.sv
// one axis lane: opposite leg by square root, then angle by cordic
// depends on ata_pkg, ata_sqrt, ata_cordic
module ata_lane import ata_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic signed [SAMPLE_WIDTH-1:0] axis_i,
  input  logic [2*SAMPLE_WIDTH-1:0]      other_sq_i,
  output logic [PROD_W-1:0]              prod_o
);

  localparam int ROOT_W = SAMPLE_WIDTH + GUARD_SHIFT;

  logic [ROOT_W-1:0]              leg;
  logic signed [SAMPLE_WIDTH-1:0] axis_q [ROOT_W];

  // axis waits alongside the square root stages
  always_ff @(posedge clk_i) begin
    axis_q[0] <= axis_i;
    for (int k = 1; k < ROOT_W; k++) begin
      axis_q[k] <= axis_q[k-1];
    end
  end

  ata_sqrt #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (other_sq_i),
    .root_o (leg)
  );

  ata_cordic #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .leg_i  (leg),
    .axis_i (axis_q[ROOT_W-1]),
    .prod_o (prod_o)
  );

endmodule

### src/ata_merge.sv
// merging stage: rounding, level shift, wrap and sign rules of the three lanes
// depends on ata_pkg
module ata_merge import ata_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  side_t                   side_i,
  input  logic [PROD_W-1:0]       prod_x_i,
  input  logic [PROD_W-1:0]       prod_y_i,
  input  logic [PROD_W-1:0]       prod_z_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] tilt_x_o,
  output logic signed [OUT_W-1:0] tilt_y_o,
  output logic signed [OUT_W-1:0] tilt_z_o,
  output logic                    degenerate_o
);

  function automatic logic [HUND_W-1:0] round_hund(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + (PROD_W'(1) << ROUND_BIT);
    return s[FRAC_BITS +: HUND_W];
  endfunction

  function automatic logic signed [LVL_W-1:0] level(input logic [HUND_W-1:0] h,
                                                    input logic neg);
    logic signed [LVL_W-1:0] t;
    t = signed'({{(LVL_W-HUND_W){1'b0}}, h});
    if (neg) begin
      t = -t;
    end
    t = t - QUARTER_TURN;
    if (t < -HALF_TURN) begin
      t = t + FULL_TURN;
    end
    return t;
  endfunction

  logic signed [LVL_W-1:0] tx_d, ty_d, tz_d;
  logic [HUND_W-1:0]       hz;

  always_comb begin
    tx_d = level(round_hund(prod_x_i), side_i.z_neg);
    ty_d = level(round_hund(prod_y_i), side_i.z_neg);
    hz   = round_hund(prod_z_i);
    tz_d = signed'({{(LVL_W-HUND_W){1'b0}}, hz});
    if (tx_d[LVL_W-1]) begin
      tz_d = -tz_d;
    end
    if (side_i.degenerate) begin
      tx_d = '0;
      ty_d = '0;
      tz_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tilt_x_o     <= tx_d[OUT_W-1:0];
    tilt_y_o     <= ty_d[OUT_W-1:0];
    tilt_z_o     <= tz_d[OUT_W-1:0];
    degenerate_o <= side_i.degenerate;
  end

endmodule

### src/accel_tilt_angles.sv
// accelerometer tilt angles: each axis angle is acos(axis / |a|) in hundredths of a degree
// three lanes of square root plus cordic, one merging stage
// depends on ata_pkg, ata_lane, ata_merge and accel_tilt_angles_macros.svh
//
// usage
// - a request is a signed sample accel_x_i, accel_y_i, accel_z_i; it is taken at a rising
//   edge with start_i high and busy_o low; busy_o stays low, so a request can come every cycle
// - each request gives one result on tilt_x_o, tilt_y_o, tilt_z_o and degenerate_o, shown for
//   exactly one cycle with done_o high; results leave in request order
// - a request passes the capture, square and sum registers, the square root and cordic
//   stages, the scaling register and the merge register before done_o is registered
// - throughput is one request per cycle: square root, cordic and scaling are fully pipelined,
//   one result bit or one rotation per stage
// - an all-zero sample gives zero angles with degenerate_o set
// - reset clears the valid and side information lines only; requests in flight are dropped
// - the receiver cannot stall, so nothing holds results back
`include "accel_tilt_angles_macros.svh"
module accel_tilt_angles import ata_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                           done_o,
  output logic signed [OUT_W-1:0]        tilt_x_o,
  output logic signed [OUT_W-1:0]        tilt_y_o,
  output logic signed [OUT_W-1:0]        tilt_z_o,
  output logic                           degenerate_o
);

  localparam int SQ_W      = 2 * SAMPLE_WIDTH;
  localparam int LANE_LAT  = SAMPLE_WIDTH + GUARD_SHIFT + CORDIC_STEPS + 1;
  localparam int TOTAL_LAT = 3 + LANE_LAT + 1;

  // fully pipelined, never pushes back
  assign busy_o = 1'b0;

  // stage a: sample capture
  logic                           va_q, vb_q, vc_q;
  logic signed [SAMPLE_WIDTH-1:0] ax_a_q, ay_a_q, az_a_q;
  logic signed [SAMPLE_WIDTH-1:0] ax_b_q, ay_b_q, az_b_q;
  logic signed [SAMPLE_WIDTH-1:0] ax_c_q, ay_c_q, az_c_q;
  logic [SQ_W-1:0]                sx_q, sy_q, sz_q;
  logic [SQ_W-1:0]                syz_q, sxz_q, sxy_q;
  logic                           deg_c_q;
  logic signed [SQ_W-1:0]         px, py, pz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= start_i && !busy_o;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // stage b: squares, stage c: sums of the two other axes
  assign px = SQ_W'(ax_a_q) * SQ_W'(ax_a_q);
  assign py = SQ_W'(ay_a_q) * SQ_W'(ay_a_q);
  assign pz = SQ_W'(az_a_q) * SQ_W'(az_a_q);

  always_ff @(posedge clk_i) begin
    ax_a_q  <= accel_x_i;
    ay_a_q  <= accel_y_i;
    az_a_q  <= accel_z_i;
    sx_q    <= px;
    sy_q    <= py;
    sz_q    <= pz;
    ax_b_q  <= ax_a_q;
    ay_b_q  <= ay_a_q;
    az_b_q  <= az_a_q;
    syz_q   <= sy_q + sz_q;
    sxz_q   <= sx_q + sz_q;
    sxy_q   <= sx_q + sy_q;
    ax_c_q  <= ax_b_q;
    ay_c_q  <= ay_b_q;
    az_c_q  <= az_b_q;
    deg_c_q <= (ax_b_q == '0) && (ay_b_q == '0) && (az_b_q == '0);
  end

  // side information rides along with the lanes
  side_t side_q [LANE_LAT];
  side_t side_in;

  always_comb begin
    side_in.valid      = vc_q;
    side_in.degenerate = deg_c_q;
    side_in.z_neg      = az_c_q[SAMPLE_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= side_in;
      for (int k = 1; k < LANE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic [PROD_W-1:0] prod_x, prod_y, prod_z;

  ata_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk_i      (clk_i),
    .axis_i     (ax_c_q),
    .other_sq_i (syz_q),
    .prod_o     (prod_x)
  );

  ata_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk_i      (clk_i),
    .axis_i     (ay_c_q),
    .other_sq_i (sxz_q),
    .prod_o     (prod_y)
  );

  ata_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk_i      (clk_i),
    .axis_i     (az_c_q),
    .other_sq_i (sxy_q),
    .prod_o     (prod_z)
  );

  ata_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .side_i       (side_q[LANE_LAT-1]),
    .prod_x_i     (prod_x),
    .prod_y_i     (prod_y),
    .prod_z_i     (prod_z),
    .done_o       (done_o),
    .tilt_x_o     (tilt_x_o),
    .tilt_y_o     (tilt_y_o),
    .tilt_z_o     (tilt_z_o),
    .degenerate_o (degenerate_o)
  );

  // every result traces back to an earlier request on start_i
  `ATA_ASSERT(a_latency, done_o |-> $past(start_i, TOTAL_LAT), "result without request")
  // a zero sample gives zero angles
  `ATA_ASSERT(a_degen_zero, (done_o && degenerate_o) |-> (tilt_x_o == '0 && tilt_y_o == '0 && tilt_z_o == '0), "degenerate result not zero")
  // a negative x angle gives a z angle that is negative or zero
  `ATA_ASSERT(a_z_sign, (done_o && tilt_x_o[OUT_W-1]) |-> (tilt_z_o[OUT_W-1] || tilt_z_o == '0), "z angle sign wrong")
  // a strobe lasts one cycle unless a new request followed
  `ATA_ASSERT_NEXT(a_strobe, done_o && !$past(start_i, TOTAL_LAT - 1), !done_o, "result strobe held")

endmodule

### sim/tb_accel_tilt_angles.sv
// self-checking bench for accel_tilt_angles: samples in, tilt angles checked in order
// integer cordic predictor kept in a small scoreboard class; depends on ata_pkg and the rtl
`timescale 1ns / 1ps
module tb_accel_tilt_angles;
  import ata_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] tx;
    logic signed [OUT_W-1:0] ty;
    logic signed [OUT_W-1:0] tz;
    logic                    degen;
  } tilt_t;

  // predicts the angles for each accepted request and checks results in order
  class tilt_scoreboard;
    tilt_t  pending[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // integer square root, exact floor
    static function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // acos(axis / length) in hundredths of a degree
    static function longint acos_hund(longint axis, longint unsigned other_sq);
      longint x, y, ang, dx, dy;
      longint unsigned prod;
      x = longint'(isqrt(other_sq << 16));
      y = -axis * 256;
      ang = 64'sd1686629713;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          ang = ang + longint'(atan_tab(i));
        end else begin
          x = x - dx;
          y = y + dy;
          ang = ang - longint'(atan_tab(i));
        end
      end
      if (ang < 0) ang = 0;
      if (ang > 64'sd3373259426) ang = 64'sd3373259426;
      prod = longint'(ang) * 5729 + (64'd1 << 29);
      return longint'(prod >> 30);
    endfunction

    static function longint unsigned atan_tab(int i);
      longint unsigned t[16] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF};
      return t[i];
    endfunction

    static function longint level(longint t, bit zneg);
      if (zneg) t = -t;
      t = t - 9000;
      if (t < -18000) t = t + 36000;
      return t;
    endfunction

    function void note_request(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
      tilt_t  e;
      longint x, y, z, tx, ty, tz;
      x = ax;
      y = ay;
      z = az;
      if (x == 0 && y == 0 && z == 0) begin
        e = '{0, 0, 0, 1'b1};
      end else begin
        tx = level(acos_hund(x, y * y + z * z), z < 0);
        ty = level(acos_hund(y, x * x + z * z), z < 0);
        tz = acos_hund(z, x * x + y * y);
        if (tx < 0) tz = -tz;
        e.tx = tx[15:0];
        e.ty = ty[15:0];
        e.tz = tz[15:0];
        e.degen = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check_result(tilt_t got);
      tilt_t e;
      if (pending.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.tx !== e.tx) begin
        $error("tilt_x expected %0d actual %0d", e.tx, got.tx); errors++;
      end
      if (got.ty !== e.ty) begin
        $error("tilt_y expected %0d actual %0d", e.ty, got.ty); errors++;
      end
      if (got.tz !== e.tz) begin
        $error("tilt_z expected %0d actual %0d", e.tz, got.tz); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate expected %0b actual %0b", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o, degenerate_o;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i;
  logic signed [OUT_W-1:0] tilt_x_o, tilt_y_o, tilt_z_o;
  tilt_scoreboard sb;

  accel_tilt_angles dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results are on the ports for one cycle only, so sample every edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result('{tilt_x_o, tilt_y_o, tilt_z_o, degenerate_o});
  end

  // one request; start_i stays high when the next follows straight on
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    accel_x_i <= x;
    accel_y_i <= y;
    accel_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(x, y, z);
  endtask

  task automatic go_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly modest vectors near a tilt, with a share of full-range noise
  function automatic logic signed [15:0] rand_axis(bit wide);
    if (wide) return 16'($urandom());
    return $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
  endfunction

  localparam logic signed [15:0] MAXV = 16'sh7FFF;
  localparam logic signed [15:0] MINV = -16'sh8000;

  initial begin
    int n, w;
    sb        = new();
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero sample, extremes, each axis alone, both signs of z
    send_sample(0, 0, 0, 0);
    send_sample(MAXV, MAXV, MAXV, 0);
    send_sample(MINV, MINV, MINV, 0);
    send_sample(MAXV, 0, 0, 0);
    send_sample(MINV, 0, 0, 0);
    send_sample(0, MAXV, 0, 0);
    send_sample(0, MINV, 0, 0);
    send_sample(0, 0, MAXV, 0);
    send_sample(0, 0, MINV, 0);
    send_sample(1, 0, 0, 0);
    send_sample(-1, 0, 0, 0);
    send_sample(0, 0, -1, 0);
    send_sample(0, 1, -1, 0);
    send_sample(1000, 0, -1, 1);
    send_sample(-1000, 0, -1, 1);
    send_sample(0, 0, 0, 1);
    send_sample(MINV, MAXV, -1, 1);
    send_sample(16'sh5555, -16'sh5556, 16'sh2AAA, 1);
    go_quiet();

    // hold off until the pipeline has drained
    while (sb.pending.size() != 0) @(posedge clk_i);

    // random with idle bursts, then a last stretch back to back
    for (n = 0; n < 1400; n++) begin
      w = ($urandom_range(0, 4) == 0);
      send_sample(rand_axis(w), rand_axis(w), rand_axis(w), n < 1200);
    end
    go_quiet();

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("accel_tilt_angles: match");
    end else begin
      $display("accel_tilt_angles: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("accel_tilt_angles: mismatch");
    $finish;
  end
endmodule
